// ----- rtl/core/rsmst_pkg.sv -----
// Shared types, constants and the pair merge for the range second-minimum sparse table.
`default_nettype none

package rsmst_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int LEVELS_DEF       = 11;

   localparam int VAL_W  = 32;
   localparam int OP_W   = 2;
   localparam int QIDX_W = 10;
   localparam int LEN_W  = QIDX_W + 1;
   localparam int QLVL_W = 4;

   localparam logic [VAL_W-1:0] NO_SECOND = 32'h7FFF_FFFF;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef struct packed {
      logic [VAL_W-1:0] lo;
      logic [VAL_W-1:0] nx;
   } pair_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic app_first;
      logic app_step;
      logic q_check;
      logic q_read;
      logic q_result;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic more;
   } sts_type;

   function automatic pair_type merge_pairs(input pair_type a, input pair_type b);
      pair_type m;
      if ($signed(a.lo) < $signed(b.lo)) begin
         m.lo = a.lo;
         m.nx = ($signed(a.nx) < $signed(b.lo)) ? a.nx : b.lo;
      end else begin
         m.lo = b.lo;
         m.nx = ($signed(b.nx) < $signed(a.lo)) ? b.nx : a.lo;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rsmst_if.sv -----
// Request and response channel interfaces.
`default_nettype none

interface rsmst_req_if;
   import rsmst_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [VAL_W-1:0]  value;
   logic [QIDX_W-1:0]        left_index;
   logic [QIDX_W-1:0]        right_index;

   modport source (output valid, output op, output value, output left_index,
                   output right_index, input ready);
   modport sink   (input valid, input op, input value, input left_index,
                   input right_index, output ready);
endinterface

interface rsmst_rsp_if;
   import rsmst_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [VAL_W-1:0]  second_min;
   logic                     range_error;

   modport source (output valid, output second_min, output range_error, input ready);
   modport sink   (input valid, input second_min, input range_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/range_second_min_sparse_table_top.sv -----
// Top level of the range second-minimum sparse table.
//
//   channel   dir  transfer            payload
//   req_chan  in   valid && ready      op, value, left_index, right_index
//   rsp_chan  out  valid && ready      second_min, range_error
//
// Append: one table write per level, set by the single write port of the
// pair table. Clear and unused op finish in the idle state.
// Query: check, two-port table read, combine, plus any wait for the
// previous response to transfer. The response register frees the
// request side while a result waits. In the datapath, reset clears the
// element count only; the table needs no clearing pass.
`default_nettype none

module range_second_min_sparse_table_top #(
   parameter int MAX_ELEMENTS = rsmst_pkg::MAX_ELEMENTS_DEF,
   parameter int LEVELS       = rsmst_pkg::LEVELS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   rsmst_req_if.sink    req_chan,
   rsmst_rsp_if.source  rsp_chan
);
   import rsmst_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rsmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rsmst_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .LEVELS       (LEVELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .value       (req_chan.value),
      .left_index  (req_chan.left_index),
      .right_index (req_chan.right_index),
      .second_min  (rsp_chan.second_min),
      .range_error (rsp_chan.range_error)
   );

endmodule

`default_nettype wire

// ----- rtl/core/rsmst_ctrl.sv -----
// Controller state machine: sequences appends, clears and queries.
`default_nettype none

module rsmst_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic [rsmst_pkg::OP_W-1:0] req_op,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire rsmst_pkg::sts_type      sts,
   output rsmst_pkg::cmd_type           cmd
);
   import rsmst_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APP_FIRST,
      ST_APP_STEP,
      ST_Q_CHECK,
      ST_Q_READ,
      ST_Q_RES
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_xfer;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd.load = 1'b1;
               case (op_type'(req_op))
                  OP_APPEND: begin
                     if (!sts.full) state_in = ST_APP_FIRST;
                  end
                  OP_QUERY: state_in = ST_Q_CHECK;
                  OP_CLEAR: cmd.clear = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_APP_FIRST: begin
            cmd.app_first = 1'b1;
            state_in      = sts.more ? ST_APP_STEP : ST_IDLE;
         end
         ST_APP_STEP: begin
            cmd.app_step = 1'b1;
            if (!sts.more) state_in = ST_IDLE;
         end
         ST_Q_CHECK: begin
            cmd.q_check = 1'b1;
            state_in    = ST_Q_READ;
         end
         ST_Q_READ: begin
            cmd.q_read = 1'b1;
            state_in   = ST_Q_RES;
         end
         ST_Q_RES: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.q_result = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rsmst_datapath.sv -----
// Datapath: pair table memory, element count, level merge and query combine.
`default_nettype none

module rsmst_datapath #(
   parameter int MAX_ELEMENTS = rsmst_pkg::MAX_ELEMENTS_DEF,
   parameter int LEVELS       = rsmst_pkg::LEVELS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rsmst_pkg::cmd_type                cmd,
   output rsmst_pkg::sts_type                     sts,
   input  wire logic signed [rsmst_pkg::VAL_W-1:0] value,
   input  wire logic [rsmst_pkg::QIDX_W-1:0]      left_index,
   input  wire logic [rsmst_pkg::QIDX_W-1:0]      right_index,
   output logic signed [rsmst_pkg::VAL_W-1:0]     second_min,
   output logic                                   range_error
);
   import rsmst_pkg::*;

   localparam int IDX_W     = $clog2(MAX_ELEMENTS);
   localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
   localparam int LVL_W     = $clog2(LEVELS);
   localparam int TGT_W     = LVL_W + 1;
   localparam int ADDR_W    = LVL_W + IDX_W;
   localparam int MEM_DEPTH = LEVELS * (2 ** IDX_W);

   pair_type mem [MEM_DEPTH];

   logic [CNT_W-1:0]  count_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [QIDX_W-1:0] left_ff, right_ff;
   logic [LVL_W-1:0]  lvl_ff;
   pair_type          carry_ff;
   logic              qerr_ff;
   logic [QLVL_W-1:0] qlvl_ff;
   pair_type          rd_a_q, rd_b_q;
   logic [VAL_W-1:0]  second_min_ff;
   logic              range_error_ff;

   logic [CNT_W-1:0]  i1;
   logic [TGT_W-1:0]  tgt;
   logic [CNT_W-1:0]  span_tgt, span_cur;
   logic              app_active, more, full;
   pair_type          merged;
   pair_type          q_merged;
   logic [LEN_W-1:0]  len, span_q, idx_b;
   logic [QLVL_W-1:0] qlvl;
   logic              qerr;
   logic [VAL_W-1:0]  res;

   logic              wr_en, rd_a_en, rd_b_en;
   logic [ADDR_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
   pair_type          wr_data;

   assign i1         = count_ff + CNT_W'(1);
   assign app_active = cmd.app_first || cmd.app_step;
   assign tgt        = cmd.app_first ? TGT_W'(1) : TGT_W'(lvl_ff) + TGT_W'(1);
   assign span_tgt   = CNT_W'(1) << tgt;
   assign span_cur   = CNT_W'(1) << lvl_ff;
   assign more       = app_active && (tgt < TGT_W'(LEVELS)) && ((i1 >> tgt) != '0);
   assign merged     = merge_pairs(rd_a_q, carry_ff);
   assign q_merged   = merge_pairs(rd_a_q, rd_b_q);
   assign full       = (count_ff >= CNT_W'(MAX_ELEMENTS));

   assign sts = '{full: full, more: more};

   assign len    = LEN_W'(right_ff) - LEN_W'(left_ff) + LEN_W'(1);
   assign span_q = LEN_W'(1) << qlvl_ff;
   assign idx_b  = LEN_W'(right_ff) + LEN_W'(1) - span_q;

   always_comb begin
      qlvl = '0;
      for (int b = 0; b < LEN_W; b++) begin
         if (len[b]) qlvl = QLVL_W'(b);
      end
   end

   assign qerr = (left_ff > right_ff)
              || (32'(right_ff) >= 32'(count_ff))
              || (len < LEN_W'(2))
              || (32'(qlvl) >= 32'(LEVELS));

   always_comb begin
      if (rd_a_q.lo == rd_b_q.lo) begin
         res = ($signed(rd_a_q.nx) < $signed(rd_b_q.nx)) ? rd_a_q.nx : rd_b_q.nx;
      end else begin
         res = q_merged.nx;
      end
   end

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = carry_ff;
      rd_a_en   = 1'b0;
      rd_a_addr = '0;
      rd_b_en   = 1'b0;
      rd_b_addr = '0;
      if (cmd.app_first) begin
         wr_en   = 1'b1;
         wr_addr = {LVL_W'(0), IDX_W'(count_ff)};
         wr_data = '{lo: value_ff, nx: NO_SECOND};
      end else if (cmd.app_step) begin
         wr_en   = 1'b1;
         wr_addr = {lvl_ff, IDX_W'(i1 - span_cur)};
         wr_data = merged;
      end
      if (more) begin
         rd_a_en   = 1'b1;
         rd_a_addr = {LVL_W'(tgt - TGT_W'(1)), IDX_W'(i1 - span_tgt)};
      end else if (cmd.q_read && !qerr_ff) begin
         rd_a_en   = 1'b1;
         rd_a_addr = {LVL_W'(qlvl_ff), IDX_W'(left_ff)};
         rd_b_en   = 1'b1;
         rd_b_addr = {LVL_W'(qlvl_ff), IDX_W'(idx_b)};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_a_en) rd_a_q <= mem[rd_a_addr];
      if (rd_b_en) rd_b_q <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (app_active && !more) begin
         count_ff <= i1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= value;
         left_ff  <= left_index;
         right_ff <= right_index;
      end
      if (cmd.app_first) begin
         carry_ff <= '{lo: value_ff, nx: NO_SECOND};
         lvl_ff   <= LVL_W'(1);
      end else if (cmd.app_step) begin
         carry_ff <= merged;
         lvl_ff   <= lvl_ff + LVL_W'(1);
      end
      if (cmd.q_check) begin
         qerr_ff <= qerr;
         qlvl_ff <= qlvl;
      end
      if (cmd.q_result) begin
         second_min_ff  <= qerr_ff ? '0 : res;
         range_error_ff <= qerr_ff;
      end
   end

   assign second_min  = $signed(second_min_ff);
   assign range_error = range_error_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rsmst_checker.sv -----
// Port-level checker for the sparse table top level, with its bind.
`default_nettype none

module rsmst_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic [rsmst_pkg::OP_W-1:0]     req_op,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic signed [rsmst_pkg::VAL_W-1:0] second_min,
   input wire logic                           range_error
);
   import rsmst_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(second_min) && $stable(range_error))
      else $error("response changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && range_error |-> second_min == '0)
      else $error("error response carries nonzero value");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_QUERY |=> !req_ready)
      else $error("request taken during query");

endmodule

bind range_second_min_sparse_table_top rsmst_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_op      (req_chan.op),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .second_min  (rsp_chan.second_min),
   .range_error (rsp_chan.range_error)
);

`default_nettype wire
